// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CapacityDef = 32;
  localparam int DataW       = 32;
  localparam int PosW        = 6;
  localparam int CountOutW   = 6;
  localparam int ReqW        = 3;
  localparam int StatusW     = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_REM_HEAD = 3'd3,
    REQ_REM_TAIL = 3'd4,
    REQ_REM_POS  = 3'd5
  } ple_req_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } ple_status_t;

  // broadcast to every cell; position travels beside it
  typedef struct packed {
    logic ins;
    logic rem;
  } ple_cmd_t;

endpackage

// File: rtl/core/positional_list_engine_core.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel in_*: one request word per handshake; in_tuser carries the
// request code, in_tdata the value and the position. Output channel out_*:
// one result word per request, carrying the removed value, status and the
// entry count after the request.
// Every cell compares the request position with its own index and keeps its
// own word or loads the new value, its left or its right neighbour's word in
// the same cycle, so a request is done in the cycle it is accepted.
// The result is registered: it sits in the output register in the cycle
// after the request is accepted. Throughput: one request per cycle while
// out_tready is high; the output register is the only buffer, so a stalled
// receiver holds the result and in_tready drops until it is taken.
// Reset (rst_n low, synchronous) empties the list and the output register;
// the cell contents are left as they are and are never read before written.
module positional_list_engine_core #(
  parameter int CAPACITY = ple_pkg::CapacityDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // item_value[31:0], position[37:32], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // removed_value[31:0], status[33:32],
                                  // entry_count[39:34]
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int EW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;

  logic             in_fire;
  ple_req_t         req;
  logic [DataW-1:0] item_value;
  logic [EW-1:0]    pos_e, cnt_e, at_e;
  ple_status_t      st;
  ple_cmd_t         cmd;
  logic [IW-1:0]    at;
  logic [DataW-1:0] taken;
  logic [EW-1:0]    cnt_out_e;

  logic [DataW-1:0] cell_val [CAPACITY];
  logic [DataW-1:0] cell_tap [CAPACITY];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign req        = ple_req_t'(in_tuser[2:0]);
  assign item_value = in_tdata[31:0];
  assign pos_e      = EW'(in_tdata[37:32]);
  assign cnt_e      = EW'(count_r);

  always_comb begin
    at_e = '0;
    st   = ST_BADPOS;
    cmd  = '0;
    unique case (req)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (req == REQ_INS_TAIL) begin
          at_e = cnt_e;
        end else if (req == REQ_INS_POS) begin
          at_e = pos_e;
        end
        if (count_r == CW'(CAPACITY)) begin
          st = ST_FULL;
        end else if (at_e > cnt_e) begin
          st = ST_BADPOS;
        end else begin
          st      = ST_OK;
          cmd.ins = in_fire;
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (req == REQ_REM_TAIL) begin
          at_e = cnt_e - EW'(1);
        end else if (req == REQ_REM_POS) begin
          at_e = pos_e;
        end
        if (count_r == '0) begin
          st = ST_EMPTY;
        end else if (at_e >= cnt_e) begin
          st = ST_BADPOS;
        end else begin
          st      = ST_OK;
          cmd.rem = in_fire;
        end
      end
      default: begin
        st = ST_BADPOS;
      end
    endcase
  end

  // only used when the request is valid, so it is below CAPACITY
  assign at = at_e[IW-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end
    ple_cell #(
      .IW    (IW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .at        (at),
      .ins_val   (item_value),
      .left_val  (left_w),
      .right_val (right_w),
      .value     (cell_val[g]),
      .tap       (cell_tap[g])
    );
  end

  always_comb begin
    taken = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken = taken | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_out_e = EW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {cnt_out_e[CountOutW-1:0], st, taken};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted insert did not grow the list");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> count_r == $past(count_r) - CW'(1))
    else $error("accepted removal did not shrink the list");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st != ST_OK) |-> taken == '0)
    else $error("failed request carries a removed value");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");
`endif

endmodule

// File: rtl/core/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell #(
  parameter int IW    = 5,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  ple_pkg::ple_cmd_t           cmd,
  input  logic [IW-1:0]               at,
  input  logic [ple_pkg::DataW-1:0]   ins_val,
  input  logic [ple_pkg::DataW-1:0]   left_val,
  input  logic [ple_pkg::DataW-1:0]   right_val,
  output logic [ple_pkg::DataW-1:0]   value,
  output logic [ple_pkg::DataW-1:0]   tap
);
  import ple_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic [DataW-1:0] value_r;
  logic [DataW-1:0] value_nxt;
  logic             here;
  logic             beyond;

  assign here   = (MyIdx == at);
  assign beyond = (MyIdx > at);

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (here) begin
        value_nxt = ins_val;
      end else if (beyond) begin
        value_nxt = left_val;
      end
    end else if (cmd.rem && (here || beyond)) begin
      value_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  // this cell's word when it is the one being removed, else zero
  assign tap   = (cmd.rem && here) ? value_r : '0;

endmodule

// File: tb/positional_list_checker.sv
`timescale 1ns / 1ps

module positional_list_checker #(
  parameter int CAPACITY = ple_pkg::CapacityDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // item_value[31:0], position[37:32], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // removed_value[31:0], status[33:32],
                                  // entry_count[39:34]
  output int          fail_count,
  output int          pending,
  output int          requests_seen,
  output int          results_seen,
  output int          full_hits,
  output int          empty_hits
);
  import ple_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]     removed;
    ple_status_t          status;
    logic [CountOutW-1:0] count;
  } list_result_t;

  logic [DataW-1:0] entries [CAPACITY];
  int unsigned      used;
  list_result_t     results_due [$];
  list_result_t     want;
  list_result_t     pred;

  initial begin
    fail_count    = 0;
    pending       = 0;
    requests_seen = 0;
    results_seen  = 0;
    full_hits     = 0;
    empty_hits    = 0;
    used          = 0;
  end

  // Applies one request to the shadow list and returns the result word it gives.
  task automatic apply_request(input logic [ReqW-1:0] code, input logic [DataW-1:0] value,
                               input logic [PosW-1:0] pos, output list_result_t res);
    int unsigned at;
    int unsigned i;
    res.removed = '0;
    res.status  = ST_OK;
    case (code)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        at = (code == REQ_INS_HEAD) ? 0 : (code == REQ_INS_TAIL) ? used : pos;
        // full takes precedence over a bad position
        if (used >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (at > used) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = used; i > at; i--) entries[i] = entries[i-1];
          entries[at] = value;
          used++;
          if (used == CAPACITY) full_hits++;
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        at = (code == REQ_REM_HEAD) ? 0 :
             (code == REQ_REM_TAIL) ? ((used == 0) ? 0 : used - 1) : pos;
        if (used == 0) begin
          res.status = ST_EMPTY;
        end else if (at >= used) begin
          res.status = ST_BADPOS;
        end else begin
          res.removed = entries[at];
          for (i = at; i + 1 < used; i++) entries[i] = entries[i+1];
          used--;
          if (used == 0) empty_hits++;
        end
      end
      default: begin
        res.status = ST_BADPOS;
      end
    endcase
    res.count = used[CountOutW-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      results_due.delete();
      used = 0;
    end else begin
      // result words first: a word leaving now belongs to an earlier request
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result word with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_tdata[31:0] !== want.removed) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(want.removed), $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[33:32] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[33:32]);
            fail_count++;
          end
          if (out_tdata[39:34] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_tdata[39:34]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        requests_seen++;
        apply_request(in_tuser, in_tdata[31:0], in_tdata[37:32], pred);
        results_due.push_back(pred);
      end
    end
    pending = results_due.size();
  end

endmodule

// File: tb/tb_positional_list_engine_core.sv
`timescale 1ns / 1ps

module tb_positional_list_engine_core;
  import ple_pkg::*;

  localparam int RandomItems = 880;
  localparam int QuietLimit  = 1000;
  localparam int SettleCycles = 10;

  // request codes with no meaning; the block must reject them
  localparam logic [ReqW-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_UNUSED_HI = 3'd7;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // item_value[31:0], position[37:32], zero pad
  logic [2:0]  in_tuser = '0;  // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;      // removed_value[31:0], status[33:32], entry_count[39:34]

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;
  int full_hits;
  int empty_hits;

  bit steady_in = 1'b0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  positional_list_checker list_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .requests_seen(requests_seen),
    .results_seen (results_seen),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits)
  );

  // Receiver: random stall after each word, with runs of no stalling.
  int  stall_left = 0;
  int  burst_left = 0;
  bit  steady_out = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else if (out_tvalid && out_tready) begin
      if (burst_left <= 0) begin
        burst_left = $urandom_range(30, 100);
        steady_out = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      stall_left = steady_out ? 0 : $urandom_range(0, 19);
      if (stall_left > 0) out_tready <= 1'b0;
    end else if (!out_tready) begin
      if (stall_left <= 1) out_tready <= 1'b1;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one request word after a random gap and holds it until taken.
  task automatic issue_request(input logic [ReqW-1:0] code, input logic [DataW-1:0] value,
                               input logic [PosW-1:0] pos);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {2'b00, pos, value};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int               n;
    int               roll;
    int               phase_left;
    trend_t           trend;
    logic [ReqW-1:0]  code;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  pos;

    phase_left = 0;
    trend      = TREND_GROW;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: all three removals, an unused code, insert past the end
    issue_request(REQ_REM_HEAD, 32'h1111_1111, 6'd0);
    issue_request(REQ_REM_TAIL, 32'h2222_2222, 6'd0);
    issue_request(REQ_REM_POS, 32'h3333_3333, 6'd63);
    issue_request(REQ_UNUSED_LO, 32'hffff_ffff, 6'd63);
    issue_request(REQ_INS_POS, 32'h1234_5678, 6'd1);
    // single entry taken out again
    issue_request(REQ_INS_HEAD, 32'h7fff_ffff, 6'd0);
    issue_request(REQ_REM_TAIL, 32'h0000_0000, 6'd0);
    issue_request(REQ_INS_TAIL, 32'h8000_0000, 6'd0);
    issue_request(REQ_INS_POS, 32'hffff_ffff, 6'd0);
    issue_request(REQ_INS_POS, 32'h0000_0000, 6'd2);  // position equal to count
    issue_request(REQ_INS_POS, 32'h5a5a_5a5a, 6'd4);
    issue_request(REQ_INS_POS, 32'ha5a5_a5a5, 6'd63);
    issue_request(REQ_INS_HEAD, 32'h0000_0001, 6'd0);
    issue_request(REQ_INS_POS, 32'h0000_0002, 6'd2);
    issue_request(REQ_UNUSED_HI, 32'h0000_0000, 6'd0);
    issue_request(REQ_REM_POS, 32'h0000_0000, 6'd5);
    issue_request(REQ_REM_POS, 32'h0000_0000, 6'd63);
    issue_request(REQ_REM_POS, 32'h0000_0000, 6'd2);
    issue_request(REQ_REM_TAIL, 32'h0000_0000, 6'd0);
    issue_request(REQ_REM_HEAD, 32'h0000_0000, 6'd0);
    issue_request(REQ_REM_POS, 32'h0000_0000, 6'd1);
    issue_request(REQ_REM_POS, 32'h0000_0000, 6'd0);

    // phases that mostly grow, mostly shrink or hover, so full and empty recur
    for (n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        trend      = trend_t'($urandom_range(0, 2));
        steady_in  = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        code = ReqW'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      end else if ((trend == TREND_GROW && roll < 75) || (trend == TREND_SHRINK && roll >= 78) ||
                   (trend == TREND_MIXED && roll < 51)) begin
        code = ReqW'($urandom_range(REQ_INS_HEAD, REQ_INS_POS));
      end else begin
        code = ReqW'($urandom_range(REQ_REM_HEAD, REQ_REM_POS));
      end
      case ($urandom_range(0, 7))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = '1;
        3:       value = '0;
        default: value = $urandom;
      endcase
      if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(0, 63));
      else pos = PosW'($urandom_range(0, CapacityDef + 1));
      issue_request(code, value, pos);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d requests, compared %0d result words", requests_seen, results_seen);
    $display("List filled to capacity %0d times and drained to empty %0d times",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine_core.sv
tb/positional_list_checker.sv
tb/tb_positional_list_engine_core.sv
